/* design/bgrb_pkg.sv */
// Shared types and constants for the bitmap glyph row blitter.
`default_nettype none

package bgrb_pkg;

    // Default sizes handed to the top level parameters
    localparam int STORE_BYTES_DEF   = 8192;
    localparam int MAX_ROWS_DEF      = 32;
    localparam int MAX_ROW_BYTES_DEF = 4;

    // Fixed field widths
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int LOAD_IDX_W  = 13;

    // Glyph chunk layout: substitute byte, advance width, then bitmap rows
    localparam int CHUNK_HEADER = 2;
    localparam int PIXEL_SHIFT  = 2;
    localparam int MAX_CODE_M1  = 254;

    // Input modes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_PEN  = 2'd1;
    localparam logic [1:0] MODE_DRAW = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BASE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_PITCH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS       = 2'd3;

    // Configuration reset values
    localparam logic [31:0] FRAME_BASE_RST = 32'd0;
    localparam logic [15:0] LINE_PITCH_RST = 16'd2560;
    localparam logic [2:0]  ROW_BYTES_RST  = 3'd1;
    localparam logic [5:0]  ROWS_RST       = 6'd16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POS_ADD,
        S_CHUNK,
        S_BASE,
        S_REDUCE,
        S_LOAD_WR,
        S_HDR,
        S_WIDTH,
        S_ROW,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

/* design/bitmap_glyph_row_blitter_core.sv */
// Glyph row blitter top level: sequencer, shared multiplier and reducer, glyph store.
`default_nettype none

// Draws bitmap font glyphs into a 32-bit-per-pixel frame buffer, one output
// word per glyph row (row start address, pixel mask with the leftmost pixel
// in the top used bit, colour, last-row flag). Input words come in three
// modes: load one glyph store byte, set the pen from an x/y position, or
// draw one character code (code zero does nothing). One input word is taken
// at a time; the block is busy until the word is fully handled. For a draw,
// the shared multiplier computes the glyph chunk offset; load indexes and
// chunk offsets are then folded into the glyph store by the shift-subtract
// reducer in K compare-and-subtract steps (3 at the default sizes). Store
// addresses wrap modulo STORE_BYTES, which need not be a power of two. The
// single glyph store read port yields one bitmap byte per cycle while the
// result register can take finished rows; when it is still full at the end
// of a row, fetching waits until it is taken. Row bytes beyond
// MAX_ROW_BYTES and rows beyond MAX_ROWS are clamped. The result stage is a
// register, so a finished row waits there while the next row's bytes are
// already being fetched. Configuration writes are always taken; write them
// only while the block is idle. The glyph store has no reset: draw only
// glyphs whose bytes were loaded.
module bitmap_glyph_row_blitter_core #(
    parameter int STORE_BYTES   = bgrb_pkg::STORE_BYTES_DEF,
    parameter int MAX_ROWS      = bgrb_pkg::MAX_ROWS_DEF,
    parameter int MAX_ROW_BYTES = bgrb_pkg::MAX_ROW_BYTES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    // Configuration write channel
    input  wire logic                             i_cfg_valid,
    output      logic                             o_cfg_ready,
    input  wire logic [bgrb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [bgrb_pkg::CFG_DATA_W-1:0]  i_cfg_data,

    // Input channel
    input  wire logic                             i_in_valid,
    output      logic                             o_in_ready,
    input  wire logic [1:0]                       i_mode,
    input  wire logic [bgrb_pkg::LOAD_IDX_W-1:0]  i_load_index,
    input  wire logic [7:0]                       i_load_byte,
    input  wire logic signed [15:0]               i_pos_x,
    input  wire logic signed [15:0]               i_pos_y,
    input  wire logic [7:0]                       i_char_code,
    input  wire logic [31:0]                      i_color,

    // Result channel
    output      logic                             o_out_valid,
    input  wire logic                             i_out_ready,
    output      logic [31:0]                      o_pixel_address,
    output      logic [31:0]                      o_pixel_mask,
    output      logic [31:0]                      o_pixel_color,
    output      logic                             o_last_row
);

    import bgrb_pkg::*;

    // Sizes derived from the parameters
    localparam int AW       = $clog2(STORE_BYTES);
    localparam int BW       = $clog2(MAX_ROW_BYTES + 1);
    localparam int RW       = $clog2(MAX_ROWS + 1);
    localparam int MASK_W   = (MAX_ROW_BYTES * 8 > 32) ? MAX_ROW_BYTES * 8 : 32;
    // Largest value the reducer ever sees: a chunk offset or a load index
    localparam int OFS_MAX  = MAX_CODE_M1 * (MAX_ROW_BYTES * MAX_ROWS + CHUNK_HEADER);
    localparam int LOAD_MAX = (1 << LOAD_IDX_W) - 1;
    localparam int RED_MAX  = (OFS_MAX > LOAD_MAX) ? OFS_MAX : LOAD_MAX;
    // STORE_BYTES << KTOP exceeds RED_MAX, so KTOP steps fold any value
    localparam int KTOP     = $clog2(RED_MAX / STORE_BYTES + 1);
    localparam int K_STEPS  = (KTOP < 1) ? 1 : KTOP;
    localparam int KW       = $clog2(K_STEPS + 1);

    // Configuration registers
    logic [31:0] r_frame_base;
    logic [15:0] r_pitch;
    logic [2:0]  r_bpr_cfg;
    logic [5:0]  r_rows_cfg;

    // Sequencer state
    t_state            r_state,    n_state;
    logic [31:0]       r_pen,      n_pen;
    logic [31:0]       r_acc,      n_acc;
    logic [15:0]       r_x,        n_x;
    logic [7:0]        r_code,     n_code;
    logic [31:0]       r_color,    n_color;
    logic [7:0]        r_byte,     n_byte;
    logic              r_is_load,  n_is_load;
    logic [KW-1:0]     r_k,        n_k;
    logic [BW-1:0]     r_bpr,      n_bpr;
    logic [RW-1:0]     r_rows,     n_rows;
    logic [7:0]        r_width,    n_width;
    logic [RW-1:0]     r_row,      n_row;
    logic [BW-1:0]     r_bcnt,     n_bcnt;
    logic [31:0]       r_row_addr, n_row_addr;
    logic [MASK_W-1:0] r_mask,     n_mask;
    logic [AW-1:0]     r_ptr,      n_ptr;

    // Result register
    logic        r_out_valid;
    logic [31:0] r_out_addr;
    logic [31:0] r_out_mask;
    logic [31:0] r_out_color;
    logic        r_out_last;

    // Glyph store
    logic [7:0] r_store [STORE_BYTES];
    logic [7:0] r_rdata;

    // Shared multiplier and helpers
    logic signed [16:0] w_mul_a;
    logic signed [16:0] w_mul_b;
    logic signed [33:0] w_prod;
    logic [31:0]        w_sub_val;
    logic [AW-1:0]      w_ptr_inc;
    logic [BW-1:0]      w_bpr_eff;
    logic [RW-1:0]      w_rows_eff;
    logic [RW-1:0]      w_row_inc;
    logic [MASK_W-1:0]  w_mask_next;
    logic               w_slot_free;
    logic               w_last_row;
    logic               w_emit;
    logic [MASK_W-1:0]  w_emit_mask;
    logic               w_we;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);

    assign o_out_valid     = r_out_valid;
    assign o_pixel_address = r_out_addr;
    assign o_pixel_mask    = r_out_mask;
    assign o_pixel_color   = r_out_color;
    assign o_last_row      = r_out_last;

    assign w_prod      = w_mul_a * w_mul_b;
    assign w_sub_val   = 32'(STORE_BYTES) << r_k;
    assign w_ptr_inc   = (r_ptr == AW'(STORE_BYTES - 1)) ? '0 : r_ptr + AW'(1);
    assign w_row_inc   = r_row + RW'(1);
    assign w_last_row  = (w_row_inc == r_rows);
    assign w_mask_next = (r_mask << 8) | MASK_W'(r_rdata);
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_we        = (r_state == S_LOAD_WR);

    // Clamp the glyph geometry to what the block is built for
    assign w_bpr_eff  = (32'(r_bpr_cfg) > 32'(MAX_ROW_BYTES)) ? BW'(MAX_ROW_BYTES)
                                                               : BW'(r_bpr_cfg);
    assign w_rows_eff = (32'(r_rows_cfg) > 32'(MAX_ROWS)) ? RW'(MAX_ROWS)
                                                           : RW'(r_rows_cfg);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base <= FRAME_BASE_RST;
            r_pitch      <= LINE_PITCH_RST;
            r_bpr_cfg    <= ROW_BYTES_RST;
            r_rows_cfg   <= ROWS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FRAME_BASE: r_frame_base <= i_cfg_data;
                REG_LINE_PITCH: r_pitch      <= i_cfg_data[15:0];
                REG_ROW_BYTES:  r_bpr_cfg    <= i_cfg_data[2:0];
                REG_ROWS:       r_rows_cfg   <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pen   <= '0;
        end else begin
            r_state <= n_state;
            r_pen   <= n_pen;
        end
    end

    // Working registers; the next state always reloads them before use
    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_x        <= n_x;
        r_code     <= n_code;
        r_color    <= n_color;
        r_byte     <= n_byte;
        r_is_load  <= n_is_load;
        r_k        <= n_k;
        r_bpr      <= n_bpr;
        r_rows     <= n_rows;
        r_width    <= n_width;
        r_row      <= n_row;
        r_bcnt     <= n_bcnt;
        r_row_addr <= n_row_addr;
        r_mask     <= n_mask;
        r_ptr      <= n_ptr;
    end

    // Glyph store: one write port, one registered read port addressed by
    // the next pointer, so r_rdata holds the byte at r_ptr when a draw reads it
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[r_ptr] <= r_byte;
        end
        r_rdata <= r_store[n_ptr];
    end

    // Result register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_addr  <= r_row_addr;
            r_out_mask  <= w_emit_mask[31:0];
            r_out_color <= r_color;
            r_out_last  <= w_last_row;
        end
    end

    // Next state and datapath control
    always_comb begin
        n_state    = r_state;
        n_pen      = r_pen;
        n_acc      = r_acc;
        n_x        = r_x;
        n_code     = r_code;
        n_color    = r_color;
        n_byte     = r_byte;
        n_is_load  = r_is_load;
        n_k        = r_k;
        n_bpr      = r_bpr;
        n_rows     = r_rows;
        n_width    = r_width;
        n_row      = r_row;
        n_bcnt     = r_bcnt;
        n_row_addr = r_row_addr;
        n_mask     = r_mask;
        n_ptr      = r_ptr;
        w_emit      = 1'b0;
        w_emit_mask = r_mask;
        // Multiplier defaults to the pen row product
        w_mul_a = {i_pos_y[15], i_pos_y};
        w_mul_b = {1'b0, r_pitch};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_mode)
                        MODE_LOAD: begin
                            n_acc     = 32'(i_load_index);
                            n_byte    = i_load_byte;
                            n_is_load = 1'b1;
                            n_k       = KW'(K_STEPS - 1);
                            n_state   = S_REDUCE;
                        end
                        MODE_PEN: begin
                            n_acc   = w_prod[31:0];
                            n_x     = i_pos_x;
                            n_state = S_POS_ADD;
                        end
                        MODE_DRAW: begin
                            if (i_char_code != 8'd0) begin
                                n_code    = i_char_code;
                                n_color   = i_color;
                                n_bpr     = w_bpr_eff;
                                n_rows    = w_rows_eff;
                                n_is_load = 1'b0;
                                n_state   = S_CHUNK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POS_ADD: begin
                n_pen   = r_frame_base + r_acc + {{14{r_x[15]}}, r_x, 2'b00};
                n_state = S_IDLE;
            end
            S_CHUNK: begin
                // Chunk size: bytes_per_row * rows plus the header
                w_mul_a = 17'(r_bpr);
                w_mul_b = 17'(r_rows);
                n_acc   = w_prod[31:0] + 32'(CHUNK_HEADER);
                n_state = S_BASE;
            end
            S_BASE: begin
                w_mul_a = {9'd0, r_code - 8'd1};
                w_mul_b = r_acc[16:0];
                n_acc   = w_prod[31:0];
                n_k     = KW'(K_STEPS - 1);
                n_state = S_REDUCE;
            end
            S_REDUCE: begin
                // Fold into the store one shifted subtract at a time
                if (r_acc >= w_sub_val) begin
                    n_acc = r_acc - w_sub_val;
                end
                if (r_k == '0) begin
                    n_ptr   = n_acc[AW-1:0];
                    n_state = r_is_load ? S_LOAD_WR : S_HDR;
                end else begin
                    n_k = r_k - KW'(1);
                end
            end
            S_LOAD_WR: begin
                n_state = S_IDLE;
            end
            S_HDR: begin
                // Skip the substitute byte
                n_ptr   = w_ptr_inc;
                n_state = S_WIDTH;
            end
            S_WIDTH: begin
                n_width    = r_rdata;
                n_row_addr = r_pen;
                n_row      = '0;
                n_bcnt     = '0;
                n_mask     = '0;
                n_ptr      = w_ptr_inc;
                if (r_rows == '0) begin
                    n_pen   = r_pen + {22'd0, r_rdata, 2'b00};
                    n_state = S_IDLE;
                end else if (r_bpr == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                n_mask = w_mask_next;
                n_ptr  = w_ptr_inc;
                n_bcnt = r_bcnt + BW'(1);
                if (n_bcnt == r_bpr) begin
                    n_bcnt = '0;
                    if (w_slot_free) begin
                        w_emit      = 1'b1;
                        w_emit_mask = w_mask_next;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    w_emit = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Row handed to the result register: advance to the next row
        if (w_emit) begin
            n_mask     = '0;
            n_row_addr = r_row_addr + 32'(r_pitch);
            n_row      = w_row_inc;
            if (w_last_row) begin
                n_pen   = r_pen + {22'd0, r_width, 2'b00};
                n_state = S_IDLE;
            end else if (r_bpr == '0) begin
                n_state = S_EMIT;
            end else begin
                n_state = S_ROW;
            end
        end
    end

    // Byte counter stays inside the row while fetching
    a_bcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW) |-> (r_bcnt < r_bpr))
        else $error("row byte counter past bytes per row");

    // Read pointer never leaves the store, also for odd store sizes
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HDR || r_state == S_WIDTH || r_state == S_ROW || r_state == S_LOAD_WR)
        |-> (32'(r_ptr) < 32'(STORE_BYTES)))
        else $error("glyph store pointer out of range");

    // Reducer output always lands inside the store
    a_reduce_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REDUCE && r_k == '0) |=> (r_acc < 32'(STORE_BYTES)))
        else $error("address fold left a value beyond the store");

    // Results appear only while a character is being drawn
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_ROW || $past(r_state) == S_EMIT))
        else $error("result word raised outside a draw");

    // A row waiting for an empty result register goes out once it empties
    a_emit_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_out_valid) |=> r_out_valid)
        else $error("pending row not emitted into an empty result register");

endmodule

`default_nettype wire
